// ===== rtl/bsa_pkg.sv =====
// bsa_pkg: shared types, sizes and helper functions of the bitmap slot allocator
// used by bsa_ram users, bitmap_slot_allocator and bsa_checker; no dependencies
package bsa_pkg;

    localparam int MAX_SLOTS  = 4096;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_W     = $clog2(WORD_COUNT);
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int HW_W       = CNT_W - BIT_W;   // word part of hint and size

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_DOUBLE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    // lowest set bit of a word
    function automatic logic [BIT_W-1:0] f_first_bit(logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    // lowest set bit of the per-word candidate vector
    function automatic logic [WORD_W-1:0] f_first_word(logic [WORD_COUNT-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (v[i]) r = WORD_W'(i);
        end
        return r;
    endfunction

endpackage

// ===== rtl/bitmap_slot_allocator.sv =====
// flow, accept to strobe: alloc, free and query pass S_SCAN then S_CHECK; alloc goes round
//   again past a hint word with no clear bit at or above the hint; a full map or an out of
//   range index found in S_SCAN ends there; one transaction at a time, taken only when idle
// reset (i_rst_n low, synchronous): bitmap reads as cleared, count = 4096, hint = 0
// the receiver cannot stall: each result is shown for exactly one cycle on o_done
// depends on bsa_pkg and bsa_ram
module bitmap_slot_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic [bsa_pkg::IDX_W-1:0] i_slot_index,
    // result channel
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [bsa_pkg::IDX_W-1:0] o_granted_index,
    output logic                      o_slot_is_free,
    output logic [bsa_pkg::CNT_W-1:0] o_free_slots,
    // configuration channel: bits_in_use
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bsa_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int WB = bsa_pkg::WORD_BITS;
    localparam int WC = bsa_pkg::WORD_COUNT;

    // control state
    bsa_pkg::t_state r_state, n_state;
    bsa_pkg::t_op    r_op, n_op;
    logic [bsa_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_retry, n_retry;    // second pass, skip the hint word
    logic [bsa_pkg::WORD_W-1:0] r_word, n_word;      // word under read-modify-write
    logic                       r_rd_ok, n_rd_ok;    // word has been written since clear
    // per-word summary bits, kept in flops
    logic [WC-1:0]              r_wvalid, n_wvalid;  // word written since last clear
    logic [WC-1:0]              r_full, n_full;      // word has all bits set
    logic [bsa_pkg::CNT_W-1:0]  r_count, n_count;
    logic [bsa_pkg::CNT_W-1:0]  r_hint, n_hint;
    logic [bsa_pkg::CNT_W-1:0]  r_size, n_size;      // bits_in_use saturated
    // result registers
    logic                       r_done, n_done;
    bsa_pkg::t_status           r_status, n_status;
    logic [bsa_pkg::IDX_W-1:0]  r_granted, n_granted;
    logic                       r_is_free, n_is_free;
    logic [bsa_pkg::CNT_W-1:0]  r_free_slots, n_free_slots;

    // ram port signals
    logic                       ram_we;
    logic [bsa_pkg::WORD_W-1:0] ram_raddr;
    logic [WB-1:0]              ram_wdata;
    logic [WB-1:0]              ram_rdata;

    // allocate search helpers
    logic [bsa_pkg::HW_W-1:0]   start_w;
    logic [bsa_pkg::HW_W-1:0]   total_w;
    logic [bsa_pkg::CNT_W-1:0]  size_round;
    logic [WC-1:0]              cand;
    logic [bsa_pkg::WORD_W-1:0] cand_w;
    logic [WB-1:0]              cur_word;    // word as read, never-written words read as zero
    logic [WB-1:0]              below_mask;  // bits under the hint in the hint word
    logic [WB-1:0]              scan_word;
    logic [bsa_pkg::BIT_W-1:0]  free_bit;
    logic [bsa_pkg::IDX_W-1:0]  res_idx;
    logic [WB-1:0]              set_word;
    logic [WB-1:0]              idx_bit;
    logic                       cfg_wr;
    logic [bsa_pkg::CNT_W-1:0]  cfg_size;

    // the bitmap itself: one word per 64 slots
    bsa_ram #(
        .WIDTH (WB),
        .DEPTH (WC)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != bsa_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == bsa_pkg::S_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_size    = (i_cfg_data > bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS))
                         ? bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS) : i_cfg_data;

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_slot_is_free  = r_is_free;
    assign o_free_slots    = r_free_slots;

    // word range of the search: from the hint word up to the last word in use
    assign start_w    = r_hint[bsa_pkg::CNT_W-1:bsa_pkg::BIT_W];
    assign size_round = r_size + bsa_pkg::CNT_W'(WB - 1);
    assign total_w    = size_round[bsa_pkg::CNT_W-1:bsa_pkg::BIT_W];

    always_comb begin
        for (int w = 0; w < WC; w++) begin
            cand[w] = !r_full[w]
                      && (r_retry ? (bsa_pkg::HW_W'(w) > start_w)
                                  : (bsa_pkg::HW_W'(w) >= start_w))
                      && (bsa_pkg::HW_W'(w) < total_w);
        end
    end

    assign cand_w = bsa_pkg::f_first_word(cand);

    // the ram data is only trusted for words written since the last clear
    assign cur_word   = r_rd_ok ? ram_rdata : '0;
    assign below_mask = ({bsa_pkg::HW_W'(r_word)} == start_w)
                        ? ~({WB{1'b1}} << r_hint[bsa_pkg::BIT_W-1:0]) : '0;
    assign scan_word  = cur_word | below_mask;
    assign free_bit   = bsa_pkg::f_first_bit(~scan_word);
    assign res_idx    = {r_word, free_bit};
    assign set_word   = cur_word | (WB'(1) << free_bit);
    assign idx_bit    = WB'(1) << r_idx[bsa_pkg::BIT_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_retry   = r_retry;
        n_word    = r_word;
        n_rd_ok   = r_rd_ok;
        n_wvalid  = r_wvalid;
        n_full    = r_full;
        n_count   = r_count;
        n_hint    = r_hint;
        n_size    = r_size;
        n_done    = 1'b0;
        n_status  = bsa_pkg::ST_OK;
        n_granted = '0;
        n_is_free = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = set_word;
        ram_raddr = r_idx[bsa_pkg::IDX_W-1:bsa_pkg::BIT_W];

        unique case (r_state)
            bsa_pkg::S_IDLE: begin
                if (start) begin
                    n_op    = bsa_pkg::t_op'(i_operation);
                    n_idx   = i_slot_index;
                    n_retry = 1'b0;
                    n_state = bsa_pkg::S_SCAN;
                end
            end
            bsa_pkg::S_SCAN: begin
                case (r_op) inside
                    bsa_pkg::OP_ALLOC: begin
                        if (r_count == '0 || cand == '0) begin
                            n_done   = 1'b1;
                            n_status = bsa_pkg::ST_FULL;
                            n_state  = bsa_pkg::S_IDLE;
                        end else begin
                            ram_raddr = cand_w;
                            n_word    = cand_w;
                            n_rd_ok   = r_wvalid[cand_w];
                            n_state   = bsa_pkg::S_CHECK;
                        end
                    end
                    bsa_pkg::OP_FREE, bsa_pkg::OP_QUERY: begin
                        if ({1'b0, r_idx} >= r_size) begin
                            n_done   = 1'b1;
                            n_status = bsa_pkg::ST_RANGE;
                            n_state  = bsa_pkg::S_IDLE;
                        end else begin
                            n_word  = r_idx[bsa_pkg::IDX_W-1:bsa_pkg::BIT_W];
                            n_rd_ok = r_wvalid[r_idx[bsa_pkg::IDX_W-1:bsa_pkg::BIT_W]];
                            n_state = bsa_pkg::S_CHECK;
                        end
                    end
                    default: begin
                        // unused selector: report ok, touch nothing
                        n_done  = 1'b1;
                        n_state = bsa_pkg::S_IDLE;
                    end
                endcase
            end
            bsa_pkg::S_CHECK: begin
                case (r_op)
                    bsa_pkg::OP_ALLOC: begin
                        if (scan_word == {WB{1'b1}}) begin
                            // only the hint word can fail; search again above it
                            n_retry = 1'b1;
                            n_state = bsa_pkg::S_SCAN;
                        end else if ({1'b0, res_idx} >= r_size) begin
                            n_done   = 1'b1;
                            n_status = bsa_pkg::ST_FULL;
                            n_state  = bsa_pkg::S_IDLE;
                        end else begin
                            ram_we           = 1'b1;
                            ram_wdata        = set_word;
                            n_wvalid[r_word] = 1'b1;
                            n_full[r_word]   = (set_word == {WB{1'b1}});
                            n_count          = r_count - 1'b1;
                            n_hint           = {1'b0, res_idx} + 1'b1;
                            n_done           = 1'b1;
                            n_granted        = res_idx;
                            n_state          = bsa_pkg::S_IDLE;
                        end
                    end
                    bsa_pkg::OP_QUERY: begin
                        n_done    = 1'b1;
                        n_is_free = !(|(cur_word & idx_bit));
                        n_state   = bsa_pkg::S_IDLE;
                    end
                    default: begin
                        // free: the hint drops even on a double free
                        if ({1'b0, r_idx} < r_hint) begin
                            n_hint = {1'b0, r_idx};
                        end
                        if (|(cur_word & idx_bit)) begin
                            ram_we           = 1'b1;
                            ram_wdata        = cur_word & ~idx_bit;
                            n_wvalid[r_word] = 1'b1;
                            n_full[r_word]   = 1'b0;
                            n_count          = r_count + 1'b1;
                        end else begin
                            n_status = bsa_pkg::ST_DOUBLE;
                        end
                        n_done  = 1'b1;
                        n_state = bsa_pkg::S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase

        // a bits_in_use write starts over with an empty map
        if (cfg_wr) begin
            n_size   = cfg_size;
            n_count  = cfg_size;
            n_hint   = '0;
            n_wvalid = '0;
            n_full   = '0;
        end

        n_free_slots = n_count;
    end

    // control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bsa_pkg::S_IDLE;
            r_wvalid <= '0;
            r_full   <= '0;
            r_count  <= bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS);
            r_hint   <= '0;
            r_size   <= bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS);
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wvalid <= n_wvalid;
            r_full   <= n_full;
            r_count  <= n_count;
            r_hint   <= n_hint;
            r_size   <= n_size;
            r_done   <= n_done;
        end
    end

    // payload and per-transaction registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_retry      <= n_retry;
        r_word       <= n_word;
        r_rd_ok      <= n_rd_ok;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_is_free    <= n_is_free;
        r_free_slots <= n_free_slots;
    end

endmodule

// ===== rtl/bsa_ram.sv =====
// bsa_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/bsa_checker.sv =====
// bsa_checker: port-level assertions for bitmap_slot_allocator, bound to the top level
// depends on bsa_pkg
module bsa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_done,
    input logic [1:0]                o_status,
    input logic [bsa_pkg::IDX_W-1:0] o_granted_index,
    input logic                      o_slot_is_free,
    input logic [bsa_pkg::CNT_W-1:0] o_free_slots
);

    // an accepted command keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted command");

    // a result is shown as the block goes idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // a granted index is only reported with ok status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != bsa_pkg::ST_OK) |-> (o_granted_index == '0))
        else $error("granted index with error status");

    // a free-slot answer never comes with an error
    a_free_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_slot_is_free) |-> (o_status == bsa_pkg::ST_OK))
        else $error("slot_is_free with error status");

    // the free-slot count shown with a result never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_free_slots <= bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS)))
        else $error("free slot count above capacity");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
